// File: hdl/pgw_pkg.sv
// Package: widths, pipeline records, sqrt step and Gaussian table for the particle weight block
`timescale 1ns / 1ps
package pgw_pkg;

  localparam int EXP_TABLE_BITS = 8;
  localparam int SPAN_LOG2      = 3;
  localparam int TABLE_LEN      = (1 << EXP_TABLE_BITS) + 1;
  localparam int IDX_W          = EXP_TABLE_BITS + 1;
  localparam int COORD_W        = 32;
  localparam int DIFF_W         = 33;
  localparam int RAD_W          = 66;
  localparam int ROOT_W         = 33;
  localparam int SQ_N           = 33;
  localparam int DIV_N          = 16 + SPAN_LOG2;
  localparam int REM_W          = ROOT_W + 16;
  localparam int CMP_W          = ROOT_W + DIV_N;
  localparam int P_W            = DIV_N + EXP_TABLE_BITS - SPAN_LOG2;
  localparam int WEIGHT_W       = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
  localparam logic [31:0] RADIUS_RST = 32'd65536;
  localparam logic [WEIGHT_W-1:0] FLOOR_RST = WEIGHT_W'(655);
  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  localparam logic ADDR_RADIUS = 1'b0;
  localparam logic ADDR_FLOOR  = 1'b1;

  typedef logic [31:0] rom_t [TABLE_LEN];

  typedef struct packed {
    logic [RAD_W-1:0] rad_d;
    logic [RAD_W-1:0] rad_s;
  } rad_pair_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic               in_rad;
    logic               szero;
    logic               far;
    logic [ROOT_W-1:0]  sigma;
    logic [REM_W-1:0]   rem;
    logic [DIV_N-1:0]   quo;
  } dv_t;

  function automatic rom_t build_rom();
    logic [63:0] y, term, q, q2, g, r;
    rom_t rom;
    y = 64'd1 << (36 - 2 * EXP_TABLE_BITS);
    term = Q31_ONE;
    q = Q31_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 31) / 64'(k);
      if (k % 2 == 1) q = q - term;
      else q = q + term;
    end
    q2 = (q * q) >> 31;
    g = Q31_ONE;
    r = q;
    rom[0] = g[31:0];
    for (int i = 1; i < TABLE_LEN; i++) begin
      g = (g * r) >> 31;
      r = (r * q2) >> 31;
      rom[i] = g[31:0];
    end
    return rom;
  endfunction

  localparam rom_t GAUSS_ROM = build_rom();

  function automatic sq_t sqrt_step(sq_t s, logic [RAD_W-1:0] b);
    logic [RAD_W:0] t;
    sq_t o;
    t = {1'b0, s.res} + {1'b0, b};
    if ({1'b0, s.rem} >= t) begin
      o.rem = s.rem - t[RAD_W-1:0];
      o.res = (s.res >> 1) + b;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

// File: hdl/pgw_queue.sv
// Short request queue between the front and back parts
`timescale 1ns / 1ps
module pgw_queue import pgw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rad_pair_t wdata,
  input  logic      pop,
  output rad_pair_t rdata,
  output logic      full,
  output logic      empty
);
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  rad_pair_t mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end
endmodule

// File: hdl/pgw_front.sv
// Front part: takes requests, forms distance and covariance sums of squares
`timescale 1ns / 1ps
module pgw_front import pgw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] particle_x,
  input  logic signed [COORD_W-1:0] particle_y,
  input  logic signed [COORD_W-1:0] measured_x,
  input  logic signed [COORD_W-1:0] measured_y,
  input  logic [COORD_W-1:0]        cov_xx,
  input  logic [COORD_W-1:0]        cov_yy,
  output logic                      push,
  output rad_pair_t                 push_data,
  input  logic                      q_full
);
  logic en;
  logic v1, v2;
  logic [DIFF_W-1:0]  adx, ady;
  logic [COORD_W-1:0] cxx, cyy;
  logic [RAD_W-2:0]   sqx, sqy;
  logic [63:0]        scx, scy;
  logic signed [DIFF_W-1:0] dx, dy;

  assign en       = !(v2 && q_full);
  assign in_stall = !en;
  assign push     = v2 && !q_full;

  assign dx = DIFF_W'(particle_x) - DIFF_W'(measured_x);
  assign dy = DIFF_W'(particle_y) - DIFF_W'(measured_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ady <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      cxx <= cov_xx;
      cyy <= cov_yy;
      sqx <= adx * adx;
      sqy <= ady * ady;
      scx <= cxx * cxx;
      scy <= cyy * cyy;
    end
  end

  assign push_data.rad_d = {1'b0, sqx} + {1'b0, sqy};
  assign push_data.rad_s = {2'b00, scx} + {2'b00, scy};
endmodule

// File: hdl/pgw_back.sv
// Back part: square roots, radius test, quotient, table interpolation, result register
`timescale 1ns / 1ps
module pgw_back import pgw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rad_pair_t           q_data,
  output logic                pop,
  input  logic [31:0]         radius_cfg,
  input  logic [WEIGHT_W-1:0] floor_cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WEIGHT_W-1:0] weight,
  output logic                inside_radius,
  output logic                sigma_zero
);
  logic en;
  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_empty;

  // square roots, one result bit per stage
  logic sq_v [SQ_N];
  sq_t  sq_d [SQ_N];
  sq_t  sq_s [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    localparam logic [RAD_W-1:0] B = RAD_W'(1) << (2 * (SQ_N - 1 - j));
    sq_t pd, ps;
    logic pv;
    if (j == 0) begin : g_first
      assign pv = !q_empty;
      assign pd = '{rem: q_data.rad_d, res: '0};
      assign ps = '{rem: q_data.rad_s, res: '0};
    end else begin : g_next
      assign pv = sq_v[j-1];
      assign pd = sq_d[j-1];
      assign ps = sq_s[j-1];
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[j] <= 1'b0;
      else if (en) sq_v[j] <= pv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_d[j] <= sqrt_step(pd, B);
        sq_s[j] <= sqrt_step(ps, B);
      end
    end
  end

  // radius test
  logic [ROOT_W-1:0] d, sg, u;
  logic c_in, c_sz;
  assign d    = sq_d[SQ_N-1].res[ROOT_W-1:0];
  assign sg   = sq_s[SQ_N-1].res[ROOT_W-1:0];
  assign c_in = d < {1'b0, radius_cfg};
  assign c_sz = !c_in && (sg == '0);
  assign u    = d - {1'b0, radius_cfg};

  logic c_v;
  dv_t  c_r;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= sq_v[SQ_N-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_r.in_rad <= c_in;
      c_r.szero  <= c_sz;
      c_r.far    <= !c_in && !c_sz &&
                    ({SPAN_LOG2'(0), u} >= ({SPAN_LOG2'(0), sg} << SPAN_LOG2));
      c_r.sigma  <= sg;
      c_r.rem    <= {u, 16'd0};
      c_r.quo    <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  logic dv_v [DIV_N];
  dv_t  dv   [DIV_N];
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int BIT = DIV_N - 1 - k;
    dv_t  p, n;
    logic pv;
    logic [CMP_W-1:0] ds;
    if (k == 0) begin : g_first
      assign p  = c_r;
      assign pv = c_v;
    end else begin : g_next
      assign p  = dv[k-1];
      assign pv = dv_v[k-1];
    end
    assign ds = CMP_W'(p.sigma) << BIT;
    always_comb begin
      n = p;
      if (CMP_W'(p.rem) >= ds) begin
        n.rem      = p.rem - ds[REM_W-1:0];
        n.quo[BIT] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (en) dv_v[k] <= pv;
    end
    always_ff @(posedge clk) begin
      if (en) dv[k] <= n;
    end
  end

  // table read
  logic [P_W-1:0]   pos;
  logic [IDX_W-1:0] idx;
  assign pos = P_W'(dv[DIV_N-1].quo) << (EXP_TABLE_BITS - SPAN_LOG2);
  assign idx = {1'b0, pos[P_W-1:16]};

  logic        r_v, r_in, r_zero;
  logic [31:0] r_g0, r_g1;
  logic [15:0] r_frac;
  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (en) r_v <= dv_v[DIV_N-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_in   <= dv[DIV_N-1].in_rad;
      r_zero <= dv[DIV_N-1].szero;
      r_g0   <= (dv[DIV_N-1].far || dv[DIV_N-1].szero) ? 32'd0 : GAUSS_ROM[idx];
      r_g1   <= (dv[DIV_N-1].far || dv[DIV_N-1].szero) ? 32'd0 : GAUSS_ROM[idx + 1'b1];
      r_frac <= pos[15:0];
    end
  end

  // interpolation product
  logic        m_v, m_in, m_zero;
  logic [31:0] m_g0;
  logic [47:0] m_prod;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= r_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_in   <= r_in;
      m_zero <= r_zero;
      m_g0   <= r_g0;
      m_prod <= (r_g0 - r_g1) * r_frac;
    end
  end

  // result
  logic [32:0]         g_rnd;
  logic [WEIGHT_W-1:0] w_raw, w;
  assign g_rnd = {1'b0, m_g0 - m_prod[47:16]} + 33'(1 << 14);
  assign w_raw = m_in ? WEIGHT_ONE : g_rnd[15+WEIGHT_W-1:15];
  assign w     = (w_raw < floor_cfg) ? floor_cfg : w_raw;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      weight        <= w;
      inside_radius <= m_in;
      sigma_zero    <= m_zero;
    end
  end
endmodule

// File: hdl/particle_gaussian_weight_flat_radius.sv
// Top level: particle weight block with configuration registers
// Path: front, queue, sqrt stages, radius test, divide stages, table, product, result.
// Throughput: one request per cycle unless stalled; sqrt and divide fully pipelined.
// The front and back stall separately across a four-entry queue.
// Reset (rst, synchronous): pipelines and queue empty, radius 1.0, weight floor 655.
`timescale 1ns / 1ps
module particle_gaussian_weight_flat_radius import pgw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] particle_x,
  input  logic signed [COORD_W-1:0] particle_y,
  input  logic signed [COORD_W-1:0] measured_x,
  input  logic signed [COORD_W-1:0] measured_y,
  input  logic [COORD_W-1:0]        cov_xx,
  input  logic [COORD_W-1:0]        cov_yy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [WEIGHT_W-1:0]       weight,
  output logic                      inside_radius,
  output logic                      sigma_zero
);
  logic [31:0]         radius_cfg;
  logic [WEIGHT_W-1:0] floor_cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg <= RADIUS_RST;
      floor_cfg  <= FLOOR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ADDR_RADIUS: radius_cfg <= pwdata;
        ADDR_FLOOR:  floor_cfg  <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_RADIUS: prdata = radius_cfg;
      ADDR_FLOOR:  prdata = 32'(floor_cfg);
      default:     prdata = '0;
    endcase
  end

  logic      push, pop, q_full, q_empty;
  rad_pair_t push_data, q_data;

  pgw_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .particle_x, .particle_y, .measured_x, .measured_y, .cov_xx, .cov_yy,
    .push, .push_data, .q_full
  );

  pgw_queue u_queue (
    .clk, .rst, .push, .wdata(push_data), .pop, .rdata(q_data),
    .full(q_full), .empty(q_empty)
  );

  pgw_back u_back (
    .clk, .rst, .q_empty, .q_data, .pop, .radius_cfg, .floor_cfg,
    .out_valid, .out_stall, .weight, .inside_radius, .sigma_zero
  );
endmodule

// File: tb/sv/particle_gaussian_weight_flat_radius_tb.sv
// Testbench: checks the particle weight block against its own predictor, under several radius and floor settings
`timescale 1ns / 1ps
module particle_gaussian_weight_flat_radius_tb;
  import pgw_pkg::*;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic                in_rad;
    logic                szero;
  } weight_res_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_FLOOR  = 3'd4
  } reg_addr_e;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [COORD_W-1:0] particle_x, particle_y, measured_x, measured_y;
  logic [COORD_W-1:0] cov_xx, cov_yy;
  logic [WEIGHT_W-1:0] weight;
  logic inside_radius, sigma_zero;

  logic [63:0]         gauss_tab [TABLE_LEN];
  logic [31:0]         radius_cfg;
  logic [WEIGHT_W-1:0] floor_cfg;
  weight_res_t         pending_weights [$];
  int                  fail_count;
  int                  idle_pct, stall_pct;

  particle_gaussian_weight_flat_radius u_dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  function automatic void fill_gauss_tab();
    logic [63:0] y, term, q, q2, g, r;
    y = 64'd1 << (36 - 2 * EXP_TABLE_BITS);
    term = 64'd1 << 31;
    q = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 31) / 64'(k);
      q = (k % 2 == 1) ? q - term : q + term;
    end
    q2 = (q * q) >> 31;
    g = 64'd1 << 31;
    r = q;
    gauss_tab[0] = g;
    for (int i = 1; i < TABLE_LEN; i++) begin
      g = (g * r) >> 31;
      r = (r * q2) >> 31;
      gauss_tab[i] = g;
    end
  endfunction

  function automatic logic [63:0] hypot_floor(logic [63:0] a, logic [63:0] b);
    logic [127:0] sum, c;
    logic [63:0] root;
    sum = 128'(a) * 128'(a) + 128'(b) * 128'(b);
    root = 0;
    for (int bit_i = 33; bit_i >= 0; bit_i--) begin
      c = 128'(root | (64'd1 << bit_i));
      if (c * c <= sum) root = c[63:0];
    end
    return root;
  endfunction

  function automatic weight_res_t predict_weight(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] mx, logic signed [31:0] my, logic [31:0] cxx, logic [31:0] cyy);
    weight_res_t res;
    longint ddx, ddy;
    logic [63:0] d, sigma, a, p, idx, frac, g, w;
    ddx = longint'(px) - longint'(mx);
    ddy = longint'(py) - longint'(my);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    d = hypot_floor(ddx, ddy);
    sigma = hypot_floor(64'(cxx), 64'(cyy));
    res.in_rad = 1'b0;
    res.szero = 1'b0;
    if (d < 64'(radius_cfg)) begin
      res.in_rad = 1'b1;
      w = 65536;
    end else if (sigma == 0) begin
      res.szero = 1'b1;
      w = 0;
    end else begin
      a = ((d - 64'(radius_cfg)) << 16) / sigma;
      if (a >= (64'd1 << (16 + SPAN_LOG2))) w = 0;
      else begin
        p = a << (EXP_TABLE_BITS - SPAN_LOG2);
        idx = p >> 16;
        frac = p & 64'hFFFF;
        g = gauss_tab[idx] - (((gauss_tab[idx] - gauss_tab[idx + 1]) * frac) >> 16);
        w = (g + (64'd1 << 14)) >> 15;
      end
    end
    if (w < 64'(floor_cfg)) w = 64'(floor_cfg);
    res.weight = w[WEIGHT_W-1:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    weight_res_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        exp_r = pending_weights.pop_front();
        if (weight !== exp_r.weight) begin
          $error("weight exp %0d got %0d", exp_r.weight, weight);
          fail_count++;
        end
        if (inside_radius !== exp_r.in_rad) begin
          $error("inside_radius exp %0d got %0d", exp_r.in_rad, inside_radius);
          fail_count++;
        end
        if (sigma_zero !== exp_r.szero) begin
          $error("sigma_zero exp %0d got %0d", exp_r.szero, sigma_zero);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(reg_addr_e addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_RADIUS) radius_cfg = data;
    else floor_cfg = data[WEIGHT_W-1:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_request(logic [31:0] px, logic [31:0] py, logic [31:0] mx,
      logic [31:0] my, logic [31:0] cxx, logic [31:0] cyy);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    particle_x = px; particle_y = py; measured_x = mx; measured_y = my;
    cov_xx = cxx; cov_yy = cyy;
    do @(posedge clk); while (in_stall);
    pending_weights.push_back(predict_weight(px, py, mx, my, cxx, cyy));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_near_item();
    logic [31:0] mx, my, off;
    int sel;
    sel = $urandom_range(19);
    mx = $urandom;
    my = $urandom;
    off = $urandom_range(0, 32'h0008_0000);
    if (sel == 0) send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (sel == 1) send_request(mx + off, my, mx, my, 0, 0);
    else
      send_request(mx + ($urandom_range(1) ? off : -off), my - $urandom_range(0, 32'h40000),
                   mx, my, $urandom_range(0, 32'h30000), $urandom_range(0, 32'h30000));
  endtask

  task automatic test_directed();
    idle_pct = 0; stall_pct = 0;
    send_request(0, 0, 0, 0, 0, 0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_request(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
    send_request(32'h0001_0000, 0, 0, 0, 0, 0);
    send_request(32'h0000_8000, 0, 0, 0, 0, 0);
    send_request(32'h0009_0000, 0, 0, 0, 32'h0001_0000, 0);
    send_request(32'h0002_0000, 0, 0, 0, 0, 32'h0001_0000);
    send_request(32'h0001_8000, 32'h0000_8000, 0, 0, 32'h0000_4000, 32'h0000_3000);
    send_request(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 1, 1);
    drain();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_FLOOR, 0);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, 32'h0001_0000, 0);
    send_request(32'h0004_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    send_request(32'h0100_0000, 0, 0, 0, 32'h0001_0000, 0);
    drain();
    write_reg(REG_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_FLOOR, 32'h0001_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_request(0, 0, 0, 0, 32'h0001_0000, 0);
    drain();
    write_reg(REG_FLOOR, 32'h0001_0000);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 5, 7);
    send_request(0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] radii [4];
    logic [31:0] floors [4];
    int idles [4];
    int stalls [4];
    radii = '{32'h0001_0000, 32'h0000_0000, 32'h0003_8000, 32'hFFFF_FFFF};
    floors = '{32'd655, 32'd0, 32'h0001_0000, 32'd12};
    idles = '{0, 88, 0, 15};
    stalls = '{0, 0, 88, 15};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_RADIUS, (ph == 0) ? $urandom_range(0, 32'h0004_0000) : radii[ph]);
      write_reg(REG_FLOOR, floors[ph]);
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      for (int n = 0; n < 300; n++) begin
        if (n % 100 == 50) begin
          idle_pct = 0;
          stall_pct = 0;
        end else if (n % 100 == 80) begin
          idle_pct = idles[ph];
          stall_pct = stalls[ph];
        end
        send_near_item();
      end
      drain();
    end
  endtask

  initial begin
    fail_count = 0;
    idle_pct = 0; stall_pct = 0;
    radius_cfg = 32'd65536;
    floor_cfg = 17'd655;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    particle_x = '0; particle_y = '0; measured_x = '0; measured_y = '0;
    cov_xx = '0; cov_yy = '0;
    fill_gauss_tab();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hdl/pgw_pkg.sv
hdl/pgw_queue.sv
hdl/pgw_front.sv
hdl/pgw_back.sv
hdl/particle_gaussian_weight_flat_radius.sv
tb/sv/particle_gaussian_weight_flat_radius_tb.sv
